FILE: src/caption_channel_demux_top_macros.svh
// assertion helpers for the caption channel demux
`ifndef CAPTION_CHANNEL_DEMUX_TOP_MACROS_SVH
`define CAPTION_CHANNEL_DEMUX_TOP_MACROS_SVH

// clocked check, off while reset is held
`define CCD_ASSERT(name, clock, resetn, prop, msg) \
  name: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// clocked check that a condition never occurs
`define CCD_ASSERT_NEVER(name, clock, resetn, cond, msg) \
  name: assert property (@(posedge clock) disable iff (!resetn) !(cond)) else $error(msg);

`endif

FILE: src/ccd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pkg
// Types and constants shared by the caption channel demux modules.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int QueueDepthDefault = 2;

  localparam logic [7:0] FILL_BYTE      = 8'h7f;
  localparam logic [7:0] CTRL_LOW       = 8'h10;
  localparam logic [7:0] CTRL_CH2_LOW   = 8'h18;
  localparam logic [7:0] CTRL_HIGH      = 8'h1f;
  localparam logic [7:0] F2_CTRL_BYTE   = 8'h15;
  localparam logic [7:0] F1_CTRL_BYTE   = 8'h14;
  localparam logic [7:0] REMAP_LOW      = 8'h20;
  localparam logic [7:0] REMAP_HIGH     = 8'h2f;
  localparam logic [7:0] CH2_FOLD       = 8'h08;

  // channel codes
  localparam logic [1:0] CH_TEXT = 2'd0;
  localparam logic [1:0] CH_ONE  = 2'd1;
  localparam logic [1:0] CH_TWO  = 2'd2;
  localparam logic [1:0] CH_XDS  = 2'd3;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] stream_index;
    logic [7:0] header_out;
    logic [7:0] first_out;
    logic [7:0] second_out;
  } out_t;

  // classified triplet handed from front to back
  typedef struct packed {
    logic       field_two;
    logic [1:0] named;
    logic [7:0] header_out;
    logic [7:0] first_out;
    logic [7:0] second_out;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic take;
    logic emit;
  } back_status_t;

endpackage
`default_nettype wire

FILE: src/ccd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_front
// Screens incoming triplets and classifies the survivors.
// ----------------------------------------------------------------------------
module ccd_front (
  input  ccd_pkg::in_t  item,
  output logic          keep,
  output ccd_pkg::cls_t cls
);

  logic       p0;
  logic       p1;
  logic       field_two;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b0_remap;
  logic [7:0] b0_fold;
  logic [1:0] named;

  assign p0 = ^item.first_byte;
  assign p1 = ^item.second_byte;
  assign field_two = item.header_byte[0];

  assign b0 = p0 ? {1'b0, item.first_byte[6:0]} : ccd_pkg::FILL_BYTE;
  assign b1 = p1 ? {1'b0, item.second_byte[6:0]} : ccd_pkg::FILL_BYTE;

  // valid bit set, line-21 type, at least one good byte, not a null pair
  assign keep = item.header_byte[2] && !item.header_byte[1] && (p0 || p1)
                && !(b0 == 8'h00 && b1 == 8'h00);

  always_comb begin
    b0_remap = b0;
    if (field_two && b0 == ccd_pkg::F2_CTRL_BYTE
        && b1 inside {[ccd_pkg::REMAP_LOW:ccd_pkg::REMAP_HIGH]}) begin
      b0_remap = ccd_pkg::F1_CTRL_BYTE;
    end
  end

  always_comb begin
    if (b0_remap inside {[ccd_pkg::CTRL_LOW:ccd_pkg::CTRL_CH2_LOW - 8'd1]}) begin
      named = ccd_pkg::CH_ONE;
    end else if (b0_remap inside {[ccd_pkg::CTRL_CH2_LOW:ccd_pkg::CTRL_HIGH]}) begin
      named = ccd_pkg::CH_TWO;
    end else if (b0_remap < ccd_pkg::CTRL_LOW) begin
      named = ccd_pkg::CH_XDS;
    end else begin
      named = ccd_pkg::CH_TEXT;
    end
  end

  // channel 2 control codes fold onto channel 1
  assign b0_fold = (named == ccd_pkg::CH_TWO) ? (b0_remap - ccd_pkg::CH2_FOLD) : b0_remap;

  assign cls.field_two  = field_two;
  assign cls.named      = named;
  assign cls.header_out = {item.header_byte[7:1], 1'b0};
  assign cls.first_out  = {~^b0_fold[6:0], b0_fold[6:0]};
  assign cls.second_out = {~^b1[6:0], b1[6:0]};

endmodule
`default_nettype wire

FILE: src/ccd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_queue
// Short flop-based queue between the front and back parts.
// ----------------------------------------------------------------------------
module ccd_queue #(
  parameter int Depth = ccd_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ccd_pkg::cls_t      din,
  input  logic               pop,
  output ccd_pkg::cls_t      dout,
  output ccd_pkg::q_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ccd_pkg::cls_t   entries_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (count_r == CntW'(Depth));
  assign status.empty = (count_r == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign dout    = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

FILE: src/ccd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_back
// Tracks the data channel of each field and fills the result register.
// ----------------------------------------------------------------------------
module ccd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  ccd_pkg::cls_t         head,
  output ccd_pkg::back_status_t status,
  output logic                  out_empty,
  input  logic                  out_pop,
  output ccd_pkg::out_t         out_item
);

  logic [1:0]    ch1_r;
  logic [1:0]    ch1_nxt;
  logic [1:0]    ch2_r;
  logic [1:0]    ch2_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  ccd_pkg::out_t out_data_r;
  logic [1:0]    cur_ch;
  logic          emit;
  logic          take;
  logic          pop_ok;

  assign pop_ok = out_pop && out_valid_r;

  always_comb begin
    if (head.named == ccd_pkg::CH_TEXT) begin
      cur_ch = head.field_two ? ch2_r : ch1_r;
    end else begin
      cur_ch = head.named;
    end
  end

  assign emit = (cur_ch == ccd_pkg::CH_ONE) || (cur_ch == ccd_pkg::CH_TWO);
  // head moves on when the result slot is free or being drained
  assign take = !q_empty && (!out_valid_r || pop_ok);

  assign status.take = take;
  assign status.emit = emit;

  always_comb begin
    ch1_nxt = ch1_r;
    ch2_nxt = ch2_r;
    if (take && head.named != ccd_pkg::CH_TEXT) begin
      if (head.field_two) begin
        ch2_nxt = head.named;
      end else begin
        ch1_nxt = head.named;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = emit;
    end else if (pop_ok) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch1_r       <= ccd_pkg::CH_ONE;
      ch2_r       <= ccd_pkg::CH_ONE;
      out_valid_r <= 1'b0;
    end else begin
      ch1_r       <= ch1_nxt;
      ch2_r       <= ch2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data_r.stream_index <= {head.field_two, cur_ch == ccd_pkg::CH_TWO};
      out_data_r.header_out   <= head.header_out;
      out_data_r.first_out    <= head.first_out;
      out_data_r.second_out   <= head.second_out;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_data_r;

endmodule
`default_nettype wire

FILE: src/caption_channel_demux_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// caption_channel_demux_top
// Line-21 caption channel demultiplexer.
// ----------------------------------------------------------------------------
// Takes one caption triplet per cycle while the queue is not full and yields
// at most one result per triplet, in order. Triplets that are invalid, not
// line-21, fully bad in parity, null pairs or extended data service produce
// no result. A kept triplet passes the internal queue and the back stage's
// result register before it reaches the out_ ports. The sustained rate is
// one triplet per cycle while results are popped as they appear, set by the
// single channel state update in the back stage and one queue read per cycle.
// The block stalls input only when the queue fills behind an unread result.
`include "caption_channel_demux_top_macros.svh"

module caption_channel_demux_top #(
  parameter int QueueDepth = ccd_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  ccd_pkg::in_t  in_item,
  output logic          out_empty,
  input  logic          out_pop,
  output ccd_pkg::out_t out_item
);

  logic                  front_keep;
  ccd_pkg::cls_t         front_cls;
  ccd_pkg::cls_t         q_head;
  ccd_pkg::q_status_t    q_status;
  ccd_pkg::back_status_t back_status;
  logic                  q_empty;
  logic                  took_result;

  ccd_front u_front (
    .item (in_item),
    .keep (front_keep),
    .cls  (front_cls)
  );

  ccd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push && front_keep),
    .din    (front_cls),
    .pop    (back_status.take),
    .dout   (q_head),
    .status (q_status)
  );

  ccd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_status.empty),
    .head      (q_head),
    .status    (back_status),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  assign in_full     = q_status.full;
  assign q_empty     = q_status.empty;
  assign took_result = back_status.take && back_status.emit;

  `CCD_ASSERT_NEVER(a_full_and_empty, clk, rst_n, in_full && q_empty, "queue full and empty")
  `CCD_ASSERT_NEVER(a_take_from_empty, clk, rst_n, back_status.take && q_empty, "empty take")
  `CCD_ASSERT(a_result_src, clk, rst_n, $fell(out_empty) |-> $past(took_result), "stray result")

endmodule
`default_nettype wire
